FILE: src/gn2d_pkg.sv
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types and constants for the two-dimensional gradient noise core.
// ----------------------------------------------------------------------------
package gn2d_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF = 10;

    localparam int COORD_W = 16;
    localparam int NODE_W  = 6;
    localparam int GRAD_W  = 8;
    localparam int ENTRY_W = 2 * GRAD_W;
    localparam int NOISE_W = 20;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_WRITE  = 1'b1
    } mode_t;

endpackage

FILE: src/gn2d_bank.sv
// ----------------------------------------------------------------------------
// gn2d_bank
// One bank of the gradient store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module gn2d_bank
    import gn2d_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/gn2d_lerp.sv
// ----------------------------------------------------------------------------
// gn2d_lerp
// Three-stage linear interpolation a + floor(w * (b - a) / 2^WF).
// ----------------------------------------------------------------------------
module gn2d_lerp
    import gn2d_pkg::*;
#(
    parameter int W  = 20,
    parameter int WF = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    input  logic [WF-1:0]       w,
    output logic                out_valid,
    output logic signed [W-1:0] y
);

    localparam int PROD_W = W + WF + 2;

    logic [2:0]               valid_reg;
    logic signed [W-1:0]      a1_reg;
    logic signed [W:0]        diff_reg;
    logic signed [W:0]        diff_next;
    logic [WF-1:0]            w1_reg;
    logic signed [W-1:0]      a2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [WF:0]       w_ext;
    logic signed [W-1:0]      y_reg;
    logic signed [W-1:0]      y_next;

    always_comb
    begin
        diff_next = {b[W-1], b} - {a[W-1], a};
        w_ext     = {1'b0, w1_reg};
        prod_next = diff_reg * w_ext;
        y_next    = a2_reg + W'(prod_reg >>> WF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a;
        diff_reg <= diff_next;
        w1_reg   <= w;
        a2_reg   <= a1_reg;
        prod_reg <= prod_next;
        y_reg    <= y_next;
    end

    assign out_valid = valid_reg[2];
    assign y         = y_reg;

endmodule

FILE: src/gradient_noise_2d_core.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_core
// Two-dimensional linear gradient noise over a loaded grid of gradients.
// ----------------------------------------------------------------------------
// The core takes one request in every clock cycle and busy stays low. A write
// request stores one node's gradient and gives no result. A sample request
// gives its noise value on noise_value with done high for exactly one cycle;
// results leave in request order and the receiver cannot hold them off. The
// path runs through the registered store read, the registered four dot
// products, the interpolation in x and the interpolation in y. The gradient
// store is split by row and column parity into four banks with one read port
// each, so the four nodes around any sample point are read in the same cycle.
// A write is seen by a sample issued in the next cycle. Nodes must be written
// before they are sampled; the store is not cleared by reset. GRID_SIZE must
// be a power of two.
module gradient_noise_2d_core
    import gn2d_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic [COORD_W-1:0]        x_coord,
    input  logic [COORD_W-1:0]        y_coord,
    input  logic [NODE_W-1:0]         node_col,
    input  logic [NODE_W-1:0]         node_row,
    input  logic signed [GRAD_W-1:0]  grad_x,
    input  logic signed [GRAD_W-1:0]  grad_y,
    output logic                      done,
    output logic signed [NOISE_W-1:0] noise_value
);

    localparam int GRID_BITS  = $clog2(GRID_SIZE);
    localparam int BANK_DEPTH = (GRID_SIZE * GRID_SIZE) / 4;
    localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int OFS_W      = FRAC_BITS + 1;
    localparam int PROD_W     = FRAC_BITS + GRAD_W + 1;
    localparam int DOT_W      = PROD_W + 1;
    localparam int EXT_W      = (DOT_W > NOISE_W) ? DOT_W : NOISE_W;
    localparam int WY_DLY     = 4;

    function automatic logic [BA_W-1:0] bank_addr(input logic [GRID_BITS-1:0] r,
                                                  input logic [GRID_BITS-1:0] c);
        return (BA_W'(r >> 1) << (GRID_BITS - 1)) | BA_W'(c >> 1);
    endfunction

    logic                  accept;
    logic                  accept_sample;
    logic                  accept_write;
    logic [COORD_W-1:0]    x_int;
    logic [COORD_W-1:0]    y_int;
    logic [GRID_BITS-1:0]  ix;
    logic [GRID_BITS-1:0]  iy;
    logic [GRID_BITS-1:0]  ix1;
    logic [GRID_BITS-1:0]  iy1;
    logic [15:0]           wcol_ext;
    logic [15:0]           wrow_ext;
    logic [GRID_BITS-1:0]  wcol;
    logic [GRID_BITS-1:0]  wrow;
    logic [ENTRY_W-1:0]    wdata;
    logic [ENTRY_W-1:0]    bank_rdata [0:3];

    logic                  s1_valid_reg;
    logic [FRAC_BITS-1:0]  wx_reg;
    logic [FRAC_BITS-1:0]  wy_reg;
    logic [1:0]            par_reg;

    logic                  s2_valid_reg;
    logic signed [DOT_W-1:0] dot_reg  [0:3];
    logic signed [DOT_W-1:0] dot_next [0:3];
    logic [FRAC_BITS-1:0]  wx2_reg;
    logic [FRAC_BITS-1:0]  wy_pipe_reg [0:WY_DLY-1];

    logic                  xl_valid;
    logic                  xl_bot_valid;
    logic signed [DOT_W-1:0] top_val;
    logic signed [DOT_W-1:0] bot_val;
    logic signed [DOT_W-1:0] res_val;
    logic signed [EXT_W-1:0] res_ext;

    assign busy          = 1'b0;
    assign accept        = start && !busy;
    assign accept_sample = accept && (mode == MODE_SAMPLE);
    assign accept_write  = accept && (mode == MODE_WRITE);

    assign x_int    = x_coord >> FRAC_BITS;
    assign y_int    = y_coord >> FRAC_BITS;
    assign ix       = x_int[GRID_BITS-1:0];
    assign iy       = y_int[GRID_BITS-1:0];
    assign ix1      = ix + GRID_BITS'(1);
    assign iy1      = iy + GRID_BITS'(1);
    assign wcol_ext = 16'(node_col);
    assign wrow_ext = 16'(node_row);
    assign wcol     = wcol_ext[GRID_BITS-1:0];
    assign wrow     = wrow_ext[GRID_BITS-1:0];
    assign wdata    = {grad_y, grad_x};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic BC = 1'(b % 2);
        localparam logic BR = 1'(b / 2);

        logic [GRID_BITS-1:0] col_sel;
        logic [GRID_BITS-1:0] row_sel;
        logic                 bank_we;

        assign col_sel = (ix[0] == BC) ? ix : ix1;
        assign row_sel = (iy[0] == BR) ? iy : iy1;
        assign bank_we = accept_write && (wcol[0] == BC) && (wrow[0] == BR);

        gn2d_bank #(
            .DEPTH  (BANK_DEPTH),
            .ADDR_W (BA_W)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (bank_addr(wrow, wcol)),
            .wdata (wdata),
            .re    (accept_sample),
            .raddr (bank_addr(row_sel, col_sel)),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept_sample;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg  <= x_coord[FRAC_BITS-1:0];
        wy_reg  <= y_coord[FRAC_BITS-1:0];
        par_reg <= {iy[0], ix[0]};
    end

    // Corner k has bit 0 set for the far column and bit 1 set for the far row.
    for (genvar k = 0; k < 4; k++)
    begin : g_dot
        logic [ENTRY_W-1:0]       entry;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [OFS_W-1:0]  ox;
        logic signed [OFS_W-1:0]  oy;
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;

        assign entry = bank_rdata[2'(k) ^ par_reg];
        assign gx    = signed'(entry[GRAD_W-1:0]);
        assign gy    = signed'(entry[ENTRY_W-1:GRAD_W]);
        assign ox    = signed'({(k % 2 == 1) ? 1'b1 : 1'b0, wx_reg});
        assign oy    = signed'({(k / 2 == 1) ? 1'b1 : 1'b0, wy_reg});
        assign px    = ox * gx;
        assign py    = oy * gy;
        assign dot_next[k] = {px[PROD_W-1], px} + {py[PROD_W-1], py};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            dot_reg[k] <= dot_next[k];
        end
        wx2_reg        <= wx_reg;
        wy_pipe_reg[0] <= wy_reg;
        for (int i = 1; i < WY_DLY; i++)
        begin
            wy_pipe_reg[i] <= wy_pipe_reg[i-1];
        end
    end

    gn2d_lerp #(
        .W  (DOT_W),
        .WF (FRAC_BITS)
    ) u_lerp_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .a         (dot_reg[0]),
        .b         (dot_reg[1]),
        .w         (wx2_reg),
        .out_valid (xl_valid),
        .y         (top_val)
    );

    gn2d_lerp #(
        .W  (DOT_W),
        .WF (FRAC_BITS)
    ) u_lerp_bot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .a         (dot_reg[2]),
        .b         (dot_reg[3]),
        .w         (wx2_reg),
        .out_valid (xl_bot_valid),
        .y         (bot_val)
    );

    gn2d_lerp #(
        .W  (DOT_W),
        .WF (FRAC_BITS)
    ) u_lerp_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xl_valid),
        .a         (top_val),
        .b         (bot_val),
        .w         (wy_pipe_reg[WY_DLY-1]),
        .out_valid (done),
        .y         (res_val)
    );

    assign res_ext     = EXT_W'(res_val);
    assign noise_value = res_ext[NOISE_W-1:0];

    // Every sample request produces exactly one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |-> ##8 done)
    else $error("sample request produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept_sample, 8))
    else $error("result without a matching sample request");

    // A write request never yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept_write |-> ##8 (done == $past(accept_sample, 8)))
    else $error("write request produced a result");

    // Both x interpolations run in lock step.
    assert property (@(posedge clk) disable iff (!rst_n)
        xl_valid == xl_bot_valid)
    else $error("x interpolation pipelines out of step");

endmodule
